### hdl/tsts_pkg.sv
`default_nettype none
package tsts_pkg;

    typedef enum logic [2:0] {
        ST_UNUSED   = 3'd0,
        ST_RUNNABLE = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_WAITING  = 3'd3,
        ST_ZOMBIE   = 3'd4
    } slot_state_t;

    typedef enum logic [1:0] {
        WK_NONE  = 2'd0,
        WK_COND  = 2'd1,
        WK_TIMER = 2'd2,
        WK_TASK  = 2'd3
    } wait_kind_t;

    typedef enum logic [3:0] {
        OP_CREATE   = 4'd0,
        OP_SCHEDULE = 4'd1,
        OP_YIELD    = 4'd2,
        OP_SUSPEND  = 4'd3,
        OP_SLEEP    = 4'd4,
        OP_WAKEUP   = 4'd5,
        OP_TERM     = 4'd6,
        OP_TICK     = 4'd7,
        OP_WAIT     = 4'd8
    } op_kind_t;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_FULL     = 3'd1;
    localparam logic [2:0] STS_NO_CUR   = 3'd2;
    localparam logic [2:0] STS_IDLE     = 3'd3;
    localparam logic [2:0] STS_SUSP     = 3'd4;
    localparam logic [2:0] STS_TIMER_ER = 3'd5;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SWEEP,
        FSM_DONE
    } fsm_state_t;

    // Per-cell command, broadcast to all cells of the row each cycle
    typedef struct packed {
        logic        active;   // a sweep step is presented to this cell
        logic [3:0]  kind;
        logic [31:0] cond;
        logic [31:0] slen;
        logic [31:0] xval;
        logic [31:0] new_id;
        logic        has_cur;
        logic [5:0]  cur;
        logic [5:0]  target;
    } cell_cmd_t;

    // What a cell reports on its visit
    typedef struct packed {
        logic        found;    // create/schedule: took this slot
        logic        woken;
        logic        timer_err;
        logic        is_target;
        logic [2:0]  state;
        logic [31:0] id;
        logic [31:0] exit_val;
    } cell_rsp_t;

endpackage
`default_nettype wire

### hdl/tsts_cell.sv
`default_nettype none
module tsts_cell
    import tsts_pkg::*;
#(
    parameter int IDX_W = 6
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] my_idx,
    input  wire logic             visit,     // this cycle's sweep slot is this cell
    input  wire logic             claim_ok,  // nothing earlier took create/schedule
    input  wire cell_cmd_t        cmd,
    input  wire logic             put_back,  // schedule: current task back to runnable
    input  wire logic             susp_task, // wait: caller parks on the target task
    output cell_rsp_t             rsp
);

    logic [2:0]  state_reg, state_next;
    logic [31:0] id_reg, id_next;
    logic [1:0]  wk_reg, wk_next;
    logic [31:0] wv_reg, wv_next;
    logic [31:0] sl_reg, sl_next;
    logic [31:0] ex_reg, ex_next;
    logic        is_cur;

    assign is_cur = cmd.has_cur && (cmd.cur[IDX_W-1:0] == my_idx) && (cmd.cur[5:IDX_W] == '0);

    // One slot's update when the sweep visits it, or when the current task is put back or parked
    always_comb
    begin
        state_next = state_reg;
        id_next    = id_reg;
        wk_next    = wk_reg;
        wv_next    = wv_reg;
        sl_next    = sl_reg;
        ex_next    = ex_reg;
        rsp        = '0;
        rsp.state    = state_reg;
        rsp.id       = id_reg;
        rsp.exit_val = ex_reg;
        rsp.is_target = (cmd.target[IDX_W-1:0] == my_idx) && (cmd.target[5:IDX_W] == '0);
        if (put_back && is_cur && state_reg == ST_RUNNING)
        begin
            state_next = ST_RUNNABLE;
        end
        else if (susp_task && is_cur)
        begin
            state_next = ST_WAITING;
            wk_next    = WK_TASK;
            wv_next    = {26'd0, cmd.target};
        end
        else if (cmd.active && visit)
        begin
            unique case (cmd.kind)
                OP_CREATE:
                begin
                    if (claim_ok && state_reg == ST_UNUSED)
                    begin
                        rsp.found  = 1'b1;
                        state_next = ST_RUNNABLE;
                        id_next    = cmd.new_id;
                        wk_next    = WK_NONE;
                        wv_next    = '0;
                        sl_next    = '0;
                        ex_next    = '0;
                    end
                end
                OP_SCHEDULE:
                begin
                    if (claim_ok)
                    begin
                        if (state_reg == ST_ZOMBIE)
                            state_next = ST_UNUSED;
                        else if (state_reg == ST_RUNNABLE)
                        begin
                            rsp.found  = 1'b1;
                            state_next = ST_RUNNING;
                        end
                    end
                end
                OP_YIELD:
                begin
                    if (is_cur)
                    begin
                        state_next = ST_RUNNABLE;
                        wk_next    = WK_NONE;
                        wv_next    = '0;
                    end
                end
                OP_SUSPEND:
                begin
                    if (is_cur)
                    begin
                        state_next = ST_WAITING;
                        wk_next    = WK_COND;
                        wv_next    = cmd.cond;
                    end
                end
                OP_SLEEP:
                begin
                    if (is_cur)
                    begin
                        state_next = ST_WAITING;
                        wk_next    = WK_TIMER;
                        wv_next    = '0;
                        sl_next    = cmd.slen;
                    end
                end
                OP_WAKEUP:
                begin
                    if (!is_cur && state_reg == ST_WAITING && wk_reg == WK_COND
                        && wv_reg == cmd.cond)
                    begin
                        rsp.woken  = 1'b1;
                        state_next = ST_RUNNABLE;
                        wk_next    = WK_NONE;
                        wv_next    = '0;
                    end
                end
                OP_TERM:
                begin
                    if (is_cur)
                    begin
                        state_next = ST_ZOMBIE;
                        ex_next    = cmd.xval;
                        wk_next    = WK_NONE;
                        wv_next    = '0;
                    end
                    else if (state_reg == ST_WAITING && wk_reg == WK_TASK
                             && wv_reg == {26'd0, cmd.cur})
                    begin
                        rsp.woken  = 1'b1;
                        state_next = ST_RUNNABLE;
                        wk_next    = WK_NONE;
                        wv_next    = '0;
                    end
                end
                OP_TICK:
                begin
                    if (state_reg == ST_WAITING && sl_reg != '0)
                    begin
                        if (wk_reg != WK_TIMER)
                            rsp.timer_err = 1'b1;
                        else
                        begin
                            sl_next = sl_reg - 32'd1;
                            if (sl_reg == 32'd1)
                            begin
                                rsp.woken  = 1'b1;
                                state_next = ST_RUNNABLE;
                                wk_next    = WK_NONE;
                                wv_next    = '0;
                            end
                        end
                    end
                end
                OP_WAIT:
                begin
                    // reap a zombie target; the caller side comes later
                    if (rsp.is_target && state_reg == ST_ZOMBIE)
                        state_next = ST_UNUSED;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_UNUSED;
            id_reg    <= '0;
            wk_reg    <= WK_NONE;
            wv_reg    <= '0;
            sl_reg    <= '0;
            ex_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            id_reg    <= id_next;
            wk_reg    <= wk_next;
            wv_reg    <= wv_next;
            sl_reg    <= sl_next;
            ex_reg    <= ex_next;
        end
    end

endmodule
`default_nettype wire

### hdl/task_state_table_scheduler.sv
// Task table scheduler.
// Request channel s_axis_*: one scheduler operation per request.
// Response channel m_axis_*: exactly one response per request, in order.
// Operations that act on one slot (yield, suspend, sleep, wait, and any
// request with nothing to sweep) pass the sweep state and then the done
// state, which registers the response. Create, schedule, wakeup, tick and
// terminate with a current task sweep the row of slot cells one slot per
// cycle (schedule from the CPU's scan pointer, the others from slot 0),
// then the done state registers the response.
// One request is in work at a time; s_axis_tready is high while idle with no
// response pending: the next request waits until the response has left.
// The response is held in an output register until m_axis_tready; a
// stalled receiver holds the block, no request is taken meanwhile.
// Reset clears all slots to unused, all CPUs to no current task, scan
// pointers, the id counter and the tick counter to zero.
// Wait on the caller's own slot suspends it permanently (only reset frees it).
// Wait reaps a zombie target in its single sweep cycle; suspension of the
// caller is applied in the final cycle of its request.
`default_nettype none
module task_state_table_scheduler
    import tsts_pkg::*;
#(
    parameter int TASK_SLOTS = 16,
    parameter int CPU_COUNT  = 4
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: kind[3:0], cpu[5:4], target_slot[9:6], condition[41:10],
    // sleep_length[73:42], exit_value[105:74], zero fill to 112
    input  wire logic [111:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: status[2:0], task_slot[6:3], task_id[38:7], exit_code_out[70:39],
    // woken_count[75:71], tick_count[107:76], zero fill to 112
    output logic [111:0]      m_axis_tdata
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    fsm_state_t fsm_reg, fsm_next;

    logic [3:0]  kind_reg;
    logic [1:0]  cpu_reg;
    logic [3:0]  tgt_reg;
    logic [31:0] cond_reg, slen_reg, xval_reg;
    logic [IDX_W-1:0] step_reg, step_next;
    logic        claimed_reg, claimed_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    logic [CNT_W-1:0] woken_reg, woken_next;
    logic        terr_reg, terr_next;
    logic        first_reg, first_next;
    logic        wait_live_reg, wait_live_next;

    logic [CPU_COUNT-1:0] cv_reg, cv_next;
    logic [IDX_W-1:0] cs_reg [CPU_COUNT];
    logic [IDX_W-1:0] cs_next [CPU_COUNT];
    logic [IDX_W-1:0] sp_reg [CPU_COUNT];
    logic [IDX_W-1:0] sp_next [CPU_COUNT];
    logic [31:0] last_id_reg, last_id_next;
    logic [31:0] ticks_reg, ticks_next;
    logic [111:0] out_reg, out_next;
    logic        ov_reg, ov_next;

    logic        cpu_ok, has_cur;
    logic [CPU_W-1:0] cpu_idx;
    logic [IDX_W-1:0] cur, visit_idx, tgt_idx;
    logic [IDX_W:0] scan_sum;
    logic        sweep_op, tgt_ok;
    logic [2:0]  status_v;
    logic [3:0]  slot_v;
    logic [31:0] id_v, tgt_id_v, xout_v;
    logic        susp_fire;

    cell_cmd_t cmd;
    cell_rsp_t rsp [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] found_v, woken_v, terr_v;

    assign cpu_idx = CPU_W'(cpu_reg);
    assign tgt_idx = IDX_W'(tgt_reg);
    assign cpu_ok  = ({30'd0, cpu_reg} < CPU_COUNT);
    assign has_cur = cpu_ok && cv_reg[cpu_idx];
    assign cur     = cs_reg[cpu_idx];
    assign tgt_ok  = ({28'd0, tgt_reg} < TASK_SLOTS);
    assign sweep_op = (kind_reg == OP_CREATE) || (kind_reg == OP_SCHEDULE && cpu_ok)
                   || (kind_reg == OP_WAKEUP) || (kind_reg == OP_TICK)
                   || (kind_reg == OP_TERM && has_cur);

    // Schedule scans from the CPU's pointer, others from slot 0
    always_comb
    begin
        scan_sum = {1'b0, sp_reg[cpu_idx]} + {1'b0, step_reg};
        if (kind_reg == OP_SCHEDULE)
        begin
            if (scan_sum >= (IDX_W+1)'(TASK_SLOTS))
                visit_idx = IDX_W'(scan_sum - (IDX_W+1)'(TASK_SLOTS));
            else
                visit_idx = IDX_W'(scan_sum);
        end
        else
            visit_idx = step_reg;
    end

    always_comb
    begin
        cmd.active  = 1'b0;
        cmd.kind    = kind_reg;
        cmd.cond    = cond_reg;
        cmd.slen    = slen_reg;
        cmd.xval    = xval_reg;
        cmd.new_id  = last_id_reg + 32'd1;
        cmd.has_cur = has_cur;
        cmd.cur     = 6'(cur);
        cmd.target  = {2'd0, tgt_reg};
        if (fsm_reg == FSM_SWEEP)
            cmd.active = sweep_op || kind_reg == OP_YIELD || kind_reg == OP_SUSPEND
                      || kind_reg == OP_SLEEP || (kind_reg == OP_WAIT && tgt_ok);
        if (!has_cur)
            cmd.active = cmd.active && !(kind_reg == OP_YIELD || kind_reg == OP_SUSPEND
                      || kind_reg == OP_SLEEP);
    end

    // Caller parks on a live target in the final cycle of a wait
    assign susp_fire = (fsm_reg == FSM_DONE) && (kind_reg == OP_WAIT) && wait_live_reg
                    && has_cur;

    // Row of slot cells
    genvar g;
    generate
        for (g = 0; g < TASK_SLOTS; g++)
        begin : g_cell
            logic vis;
            always_comb
            begin
                if (kind_reg == OP_YIELD || kind_reg == OP_SUSPEND || kind_reg == OP_SLEEP)
                    vis = (IDX_W'(g) == cur);
                else if (kind_reg == OP_WAIT)
                    vis = (IDX_W'(g) == tgt_idx) && first_reg;
                else
                    vis = (IDX_W'(g) == visit_idx);
            end
            tsts_cell #(.IDX_W(IDX_W)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .my_idx    (IDX_W'(g)),
                .visit     (vis),
                .claim_ok  (!claimed_reg),
                .cmd       (cmd),
                .put_back  (fsm_reg == FSM_SWEEP && first_reg && kind_reg == OP_SCHEDULE
                            && has_cur),
                .susp_task (susp_fire),
                .rsp       (rsp[g])
            );
            assign found_v[g] = rsp[g].found;
            assign woken_v[g] = rsp[g].woken;
            assign terr_v[g]  = rsp[g].timer_err;
        end
    endgenerate

    // Wait target readout
    always_comb
    begin
        xout_v   = '0;
        tgt_id_v = '0;
        if (tgt_ok)
        begin
            tgt_id_v = rsp[tgt_idx].id;
            if (rsp[tgt_idx].state == ST_ZOMBIE)
                xout_v = rsp[tgt_idx].exit_val;
        end
    end

    // Sequencer
    always_comb
    begin
        fsm_next     = fsm_reg;
        step_next    = step_reg;
        claimed_next = claimed_reg;
        hit_next     = hit_reg;
        woken_next   = woken_reg;
        terr_next    = terr_reg;
        first_next   = first_reg;
        wait_live_next = wait_live_reg;
        cv_next      = cv_reg;
        cs_next      = cs_reg;
        sp_next      = sp_reg;
        last_id_next = last_id_reg;
        ticks_next   = ticks_reg;
        out_next     = out_reg;
        ov_next      = ov_reg;
        status_v     = STS_OK;
        slot_v       = '0;
        id_v         = '0;
        s_axis_tready = (fsm_reg == FSM_IDLE) && !ov_reg;
        if (ov_reg && m_axis_tready)
            ov_next = 1'b0;
        unique case (fsm_reg)
            FSM_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    fsm_next     = FSM_SWEEP;
                    step_next    = '0;
                    claimed_next = 1'b0;
                    hit_next     = '0;
                    woken_next   = '0;
                    terr_next    = 1'b0;
                    first_next   = 1'b1;
                    wait_live_next = 1'b0;
                end
            end
            FSM_SWEEP:
            begin
                first_next = 1'b0;
                if (|found_v)
                begin
                    claimed_next = 1'b1;
                    hit_next     = visit_idx;
                end
                woken_next = woken_reg + CNT_W'($countones(woken_v));
                terr_next  = terr_reg | (|terr_v);
                if (sweep_op && step_reg != IDX_W'(TASK_SLOTS - 1))
                    step_next = step_reg + IDX_W'(1);
                else
                    fsm_next = FSM_DONE;
                if (kind_reg == OP_WAIT)
                begin
                    // Readout before the cell frees a zombie target
                    out_next[70:39] = xout_v;
                    out_next[38:7]  = tgt_id_v;
                    wait_live_next  = tgt_ok && rsp[tgt_idx].state != ST_ZOMBIE
                                   && rsp[tgt_idx].state != ST_UNUSED;
                end
                if (kind_reg == OP_CREATE && |found_v)
                    last_id_next = last_id_reg + 32'd1;
                if (kind_reg == OP_TICK && first_reg)
                    ticks_next = ticks_reg + 32'd1;
            end
            FSM_DONE:
            begin
                fsm_next = FSM_IDLE;
                ov_next  = 1'b1;
                out_next[111:108] = '0;
                out_next[70:39]   = (kind_reg == OP_WAIT) ? out_reg[70:39] : 32'd0;
                id_v = (kind_reg == OP_WAIT) ? out_reg[38:7] : 32'd0;
                unique case (kind_reg)
                    OP_CREATE:
                    begin
                        if (claimed_reg)
                        begin
                            slot_v = 4'(hit_reg);
                            id_v   = last_id_reg;
                        end
                        else
                            status_v = STS_FULL;
                    end
                    OP_SCHEDULE:
                    begin
                        status_v = STS_IDLE;
                        if (cpu_ok)
                        begin
                            cv_next[cpu_idx] = claimed_reg;
                            if (claimed_reg)
                            begin
                                status_v = STS_OK;
                                slot_v   = 4'(hit_reg);
                                id_v     = rsp[hit_reg].id;
                                cs_next[cpu_idx] = hit_reg;
                                sp_next[cpu_idx] = (hit_reg == IDX_W'(TASK_SLOTS - 1))
                                                 ? '0 : hit_reg + IDX_W'(1);
                            end
                        end
                    end
                    OP_YIELD, OP_SUSPEND, OP_SLEEP, OP_TERM:
                    begin
                        if (!has_cur)
                            status_v = STS_NO_CUR;
                        else
                        begin
                            slot_v = 4'(cur);
                            id_v   = rsp[cur].id;
                            cv_next[cpu_idx] = 1'b0;
                            if (kind_reg == OP_SUSPEND || kind_reg == OP_SLEEP)
                                status_v = STS_SUSP;
                        end
                    end
                    OP_TICK:
                    begin
                        if (terr_reg)
                            status_v = STS_TIMER_ER;
                    end
                    OP_WAIT:
                    begin
                        if (tgt_ok)
                        begin
                            slot_v = tgt_reg;
                            if (wait_live_reg)
                            begin
                                if (!has_cur)
                                    status_v = STS_NO_CUR;
                                else
                                begin
                                    status_v = STS_SUSP;
                                    cv_next[cpu_idx] = 1'b0;
                                end
                            end
                        end
                        else
                            id_v = '0;
                    end
                    default:
                    begin
                    end
                endcase
                out_next[2:0]    = status_v;
                out_next[6:3]    = slot_v;
                out_next[38:7]   = id_v;
                out_next[75:71]  = (kind_reg == OP_WAKEUP || kind_reg == OP_TERM
                                    || kind_reg == OP_TICK) ? 5'(woken_reg) : 5'd0;
                out_next[107:76] = ticks_next;
            end
            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg     <= FSM_IDLE;
            step_reg    <= '0;
            claimed_reg <= 1'b0;
            hit_reg     <= '0;
            woken_reg   <= '0;
            terr_reg    <= 1'b0;
            first_reg   <= 1'b0;
            cv_reg      <= '0;
            for (int c = 0; c < CPU_COUNT; c++)
            begin
                cs_reg[c] <= '0;
                sp_reg[c] <= '0;
            end
            last_id_reg <= '0;
            ticks_reg   <= '0;
            ov_reg      <= 1'b0;
            wait_live_reg <= 1'b0;
        end
        else
        begin
            fsm_reg     <= fsm_next;
            step_reg    <= step_next;
            claimed_reg <= claimed_next;
            hit_reg     <= hit_next;
            woken_reg   <= woken_next;
            terr_reg    <= terr_next;
            first_reg   <= first_next;
            cv_reg      <= cv_next;
            cs_reg      <= cs_next;
            sp_reg      <= sp_next;
            last_id_reg <= last_id_next;
            ticks_reg   <= ticks_next;
            ov_reg      <= ov_next;
            wait_live_reg <= wait_live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fsm_reg == FSM_IDLE && s_axis_tvalid && s_axis_tready)
        begin
            kind_reg <= s_axis_tdata[3:0];
            cpu_reg  <= s_axis_tdata[5:4];
            tgt_reg  <= s_axis_tdata[9:6];
            cond_reg <= s_axis_tdata[41:10];
            slen_reg <= s_axis_tdata[73:42];
            xval_reg <= s_axis_tdata[105:74];
        end
        out_reg <= out_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    a_one_found: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(found_v)) else $error("two slots claimed");
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg != FSM_IDLE |-> !s_axis_tready) else $error("ready while busy");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == FSM_DONE |=> m_axis_tvalid) else $error("lost response");
`endif

endmodule
`default_nettype wire

### tb/task_state_table_scheduler_tb.sv
`default_nettype none
module task_state_table_scheduler_tb;
    import tsts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int CPUS = 4;
    localparam int RANDOM_REQS = 1130;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] exit_value;
        logic [31:0] sleep_length;
        logic [31:0] condition;
        logic [3:0]  target_slot;
        logic [1:0]  cpu;
        logic [3:0]  kind;
    } sched_req_t;

    typedef struct packed {
        logic [31:0] tick_count;
        logic [4:0]  woken_count;
        logic [31:0] exit_code_out;
        logic [31:0] task_id;
        logic [3:0]  task_slot;
        logic [2:0]  status;
    } sched_rsp_t;

    // one directed step; check_fixed compares against the typed response too
    typedef struct {
        sched_req_t req;
        bit         check_fixed;
        sched_rsp_t fixed;
    } directed_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;   // kind, cpu, target_slot, condition, sleep_length, exit_value
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;   // status, task_slot, task_id, exit_code_out, woken, ticks

    task_state_table_scheduler i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // shadow task table
    slot_state_t tbl_state [SLOTS];
    logic [31:0] tbl_id    [SLOTS];
    wait_kind_t  tbl_wkind [SLOTS];
    logic [31:0] tbl_wval  [SLOTS];
    logic [31:0] tbl_sleep [SLOTS];
    logic [31:0] tbl_exit  [SLOTS];
    bit          cpu_busy  [CPUS];
    logic [3:0]  cpu_slot  [CPUS];
    logic [3:0]  cpu_scan  [CPUS];
    logic [31:0] id_counter;
    logic [31:0] tick_total;

    sched_rsp_t expected_rsps[$];
    int mismatch_count;
    int idle_cycles = 0;
    bit stimulus_done;

    function automatic void wake_slot(int s);
        tbl_state[s] = ST_RUNNABLE;
        tbl_wkind[s] = WK_NONE;
        tbl_wval[s] = '0;
    endfunction

    // computes the response of one request and advances the shadow table
    function automatic sched_rsp_t sched_predict(sched_req_t r);
        sched_rsp_t o;
        bit has_cur;
        int cur;
        int s;
        o = '0;
        has_cur = cpu_busy[r.cpu];
        cur = cpu_slot[r.cpu];
        case (r.kind)
            OP_CREATE:
            begin
                o.status = STS_FULL;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_state[i] == ST_UNUSED)
                    begin
                        id_counter++;
                        tbl_id[i] = id_counter;
                        tbl_state[i] = ST_RUNNABLE;
                        tbl_wkind[i] = WK_NONE;
                        tbl_wval[i] = '0;
                        tbl_sleep[i] = '0;
                        tbl_exit[i] = '0;
                        o.status = STS_OK;
                        o.task_slot = i;
                        o.task_id = id_counter;
                        break;
                    end
            end
            OP_SCHEDULE:
            begin
                o.status = STS_IDLE;
                if (has_cur)
                begin
                    if (tbl_state[cur] == ST_RUNNING)
                        tbl_state[cur] = ST_RUNNABLE;
                    cpu_busy[r.cpu] = 0;
                end
                for (int i = 0; i < SLOTS; i++)
                begin
                    s = (cpu_scan[r.cpu] + i) % SLOTS;
                    if (tbl_state[s] == ST_ZOMBIE)
                        tbl_state[s] = ST_UNUSED;
                    else if (tbl_state[s] == ST_RUNNABLE)
                    begin
                        tbl_state[s] = ST_RUNNING;
                        cpu_busy[r.cpu] = 1;
                        cpu_slot[r.cpu] = s;
                        cpu_scan[r.cpu] = (s + 1) % SLOTS;
                        o.status = STS_OK;
                        o.task_slot = s;
                        o.task_id = tbl_id[s];
                        break;
                    end
                end
            end
            OP_YIELD, OP_SUSPEND, OP_SLEEP, OP_TERM:
            begin
                if (!has_cur)
                    o.status = STS_NO_CUR;
                else
                begin
                    o.task_slot = cur;
                    o.task_id = tbl_id[cur];
                    cpu_busy[r.cpu] = 0;
                    if (r.kind == OP_YIELD)
                        wake_slot(cur);
                    else if (r.kind == OP_SUSPEND)
                    begin
                        tbl_state[cur] = ST_WAITING;
                        tbl_wkind[cur] = WK_COND;
                        tbl_wval[cur] = r.condition;
                        o.status = STS_SUSP;
                    end
                    else if (r.kind == OP_SLEEP)
                    begin
                        tbl_sleep[cur] = r.sleep_length;
                        tbl_state[cur] = ST_WAITING;
                        tbl_wkind[cur] = WK_TIMER;
                        tbl_wval[cur] = '0;
                        o.status = STS_SUSP;
                    end
                    else
                    begin
                        tbl_state[cur] = ST_ZOMBIE;
                        tbl_exit[cur] = r.exit_value;
                        tbl_wkind[cur] = WK_NONE;
                        tbl_wval[cur] = '0;
                        for (int i = 0; i < SLOTS; i++)
                            if (i != cur && tbl_state[i] == ST_WAITING &&
                                tbl_wkind[i] == WK_TASK && tbl_wval[i] == cur)
                            begin
                                wake_slot(i);
                                o.woken_count++;
                            end
                    end
                end
            end
            OP_WAKEUP:
                for (int i = 0; i < SLOTS; i++)
                    if (!(has_cur && i == cur) && tbl_state[i] == ST_WAITING &&
                        tbl_wkind[i] == WK_COND && tbl_wval[i] == r.condition)
                    begin
                        wake_slot(i);
                        o.woken_count++;
                    end
            OP_TICK:
            begin
                tick_total++;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_state[i] == ST_WAITING && tbl_sleep[i] != 0)
                    begin
                        if (tbl_wkind[i] != WK_TIMER)
                            o.status = STS_TIMER_ER;
                        else
                        begin
                            tbl_sleep[i]--;
                            if (tbl_sleep[i] == 0)
                            begin
                                wake_slot(i);
                                o.woken_count++;
                            end
                        end
                    end
            end
            OP_WAIT:
            begin
                s = r.target_slot;
                o.task_slot = s;
                o.task_id = tbl_id[s];
                if (tbl_state[s] == ST_ZOMBIE)
                begin
                    o.exit_code_out = tbl_exit[s];
                    tbl_state[s] = ST_UNUSED;
                end
                else if (tbl_state[s] != ST_UNUSED)
                begin
                    if (!has_cur)
                        o.status = STS_NO_CUR;
                    else
                    begin
                        cpu_busy[r.cpu] = 0;
                        tbl_state[cur] = ST_WAITING;
                        tbl_wkind[cur] = WK_TASK;
                        tbl_wval[cur] = s;
                        o.status = STS_SUSP;
                    end
                end
            end
            default: ;
        endcase
        o.tick_count = tick_total;
        return o;
    endfunction

    function automatic sched_req_t make_req(op_kind_t k, int c, int t = 0,
                                            logic [31:0] cnd = 0,
                                            logic [31:0] sl = 0,
                                            logic [31:0] xv = 0);
        sched_req_t r;
        r.kind = k;
        r.cpu = c;
        r.target_slot = t;
        r.condition = cnd;
        r.sleep_length = sl;
        r.exit_value = xv;
        return r;
    endfunction

    function automatic sched_rsp_t make_rsp(logic [2:0] st, int sl = 0,
                                            logic [31:0] id = 0,
                                            logic [31:0] xo = 0,
                                            int wk = 0, logic [31:0] tk = 0);
        sched_rsp_t o;
        o.status = st;
        o.task_slot = sl;
        o.task_id = id;
        o.exit_code_out = xo;
        o.woken_count = wk;
        o.tick_count = tk;
        return o;
    endfunction

    // pick a random request, biased toward a busy table with live operations
    function automatic sched_req_t random_req();
        sched_req_t r;
        int pick;
        r.kind = OP_CREATE;
        r.cpu = $urandom_range(0, CPUS - 1);
        r.target_slot = $urandom_range(0, SLOTS - 1);
        r.condition = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
        r.sleep_length = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
        r.exit_value = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 12)      r.kind = OP_CREATE;
        else if (pick < 34) r.kind = OP_SCHEDULE;
        else if (pick < 41) r.kind = OP_YIELD;
        else if (pick < 48) r.kind = OP_SUSPEND;
        else if (pick < 55) r.kind = OP_SLEEP;
        else if (pick < 64) r.kind = OP_WAKEUP;
        else if (pick < 72) r.kind = OP_TERM;
        else if (pick < 84) r.kind = OP_TICK;
        else if (pick < 98) r.kind = OP_WAIT;
        else                r.kind = $urandom_range(9, 15);
        // a wait on the caller's own slot parks it for good; keep it rare
        if (r.kind == OP_WAIT && cpu_busy[r.cpu] && r.target_slot == cpu_slot[r.cpu]
            && $urandom_range(0, 19) != 0)
            r.target_slot = r.target_slot + 1;
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // watchdog on cycles without any accepted request or response
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // response side: random stall, compare with the oldest expectation
    initial
    begin
        sched_rsp_t got;
        sched_rsp_t want;
        int stall;
        m_axis_tready = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_axis_tready <= 0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1;
            @(posedge clk iff m_axis_tvalid);
            got = m_axis_tdata[107:0];
            if (expected_rsps.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response %p", got);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    task automatic send_req(sched_req_t r, bit check_fixed, sched_rsp_t fixed);
        sched_rsp_t p;
        int gap;
        gap = stimulus_done ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {6'd0, r};
        s_axis_tvalid <= 1;
        @(posedge clk iff s_axis_tready);
        p = sched_predict(r);
        if (check_fixed && p !== fixed)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("table row: expected %p predicted %p", fixed, p);
        end
        expected_rsps.push_back(p);
    endtask

    initial
    begin
        directed_row_t rows[$];
        directed_row_t row;
        int drain;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        rst_n = 0;
        mismatch_count = 0;
        stimulus_done = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_state[i] = ST_UNUSED;
            tbl_id[i] = '0;
            tbl_wkind[i] = WK_NONE;
            tbl_wval[i] = '0;
            tbl_sleep[i] = '0;
            tbl_exit[i] = '0;
        end
        for (int c = 0; c < CPUS; c++)
        begin
            cpu_busy[c] = 0;
            cpu_slot[c] = '0;
            cpu_scan[c] = '0;
        end
        id_counter = '0;
        tick_total = '0;

        // directed table
        rows.push_back('{make_req(OP_SCHEDULE, 0), 1, make_rsp(STS_IDLE)});
        rows.push_back('{make_req(OP_YIELD, 1), 1, make_rsp(STS_NO_CUR)});
        rows.push_back('{make_req(OP_WAIT, 2, 15), 1, make_rsp(STS_OK, 15)});
        rows.push_back('{make_req(op_kind_t'(4'd15), 3, 15, '1, '1, '1), 1,
                         make_rsp(STS_OK)});
        rows.push_back('{make_req(OP_TICK, 0), 1, make_rsp(STS_OK, 0, 0, 0, 0, 1)});
        rows.push_back('{make_req(OP_CREATE, 0), 1, make_rsp(STS_OK, 0, 1, 0, 0, 1)});
        rows.push_back('{make_req(OP_CREATE, 0), 1, make_rsp(STS_OK, 1, 2, 0, 0, 1)});
        rows.push_back('{make_req(OP_SCHEDULE, 0), 1, make_rsp(STS_OK, 0, 1, 0, 0, 1)});
        rows.push_back('{make_req(OP_SCHEDULE, 1), 0, '0});
        rows.push_back('{make_req(OP_WAIT, 0, 1), 0, '0});
        rows.push_back('{make_req(OP_TERM, 1, 0, 0, 0, 32'h8000_0000), 0, '0});
        rows.push_back('{make_req(OP_SCHEDULE, 2), 0, '0});
        rows.push_back('{make_req(OP_WAIT, 2, 1), 0, '0});
        rows.push_back('{make_req(OP_SUSPEND, 2, 0, 32'hFFFF_FFFF), 0, '0});
        rows.push_back('{make_req(OP_WAKEUP, 3, 0, 32'hFFFF_FFFF), 0, '0});
        rows.push_back('{make_req(OP_SCHEDULE, 3), 0, '0});
        rows.push_back('{make_req(OP_SLEEP, 3, 0, 0, 32'd2), 0, '0});
        rows.push_back('{make_req(OP_TICK, 1), 0, '0});
        rows.push_back('{make_req(OP_TICK, 1), 0, '0});
        rows.push_back('{make_req(OP_SCHEDULE, 0), 0, '0});
        rows.push_back('{make_req(OP_SLEEP, 0, 0, 0, 32'hFFFF_FFFF), 0, '0});
        for (int i = 0; i < SLOTS; i++)
            rows.push_back('{make_req(OP_CREATE, i % CPUS), 0, '0});
        rows.push_back('{make_req(OP_CREATE, 0), 1, make_rsp(STS_FULL, 0, 0, 0, 0, 3)});

        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            send_req(row.req, row.check_fixed, row.fixed);
        end
        s_axis_tvalid <= 0;

        // let every response drain once before the random part
        wait (expected_rsps.size() == 0);
        @(posedge clk);

        for (int n = 0; n < RANDOM_REQS; n++)
            send_req(random_req(), 0, '0);
        s_axis_tvalid <= 0;

        stimulus_done = 1;
        drain = 0;
        while (expected_rsps.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_rsps.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

### task_state_table_scheduler.f
hdl/tsts_pkg.sv
hdl/tsts_cell.sv
hdl/task_state_table_scheduler.sv
tb/task_state_table_scheduler_tb.sv
